@@ hw/rtl/lpfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types and codes for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

	// Parser phase
	typedef enum logic [1:0] {
		PH_ID     = 2'd0,
		PH_LEN_HI = 2'd1,
		PH_LEN_LO = 2'd2,
		PH_DATA   = 2'd3
	} phase_t;

	// Result event codes
	typedef enum logic [2:0] {
		EV_HEADER   = 3'd0,
		EV_PAYLOAD  = 3'd1,
		EV_GOOD     = 3'd2,
		EV_BAD_SUM  = 3'd3,
		EV_BAD_ID   = 3'd4,
		EV_OVERSIZE = 3'd5
	} event_t;

	// Register indexes (byte address = 4 * index)
	localparam logic REG_FRAME_ID   = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	localparam logic [7:0]  FRAME_ID_RESET   = 8'h00;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;

endpackage

@@ hw/rtl/length_prefixed_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Parses ID / 16-bit length / payload / additive checksum frames from a byte
// stream and reports one event item per received byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : in_valid / in_ready carry rx_byte, one received byte per
//                    item.
//   Output channel : out_valid / out_ready carry event_res, payload_byte,
//                    payload_index and computed_sum; every input item yields
//                    exactly one output item.
//   Config port    : APB-style, frame_id at byte address 0, max_length at 4.
//                    pready is tied high; write only while the block is idle.
//   Output timing  : out_valid is registered, set in the cycle after accept.
//   Throughput     : one item per cycle while out_ready is high. The parse
//                    state and result register are updated in the same cycle
//                    as the accept, so the next byte can follow directly.
//   Stall          : in_ready is high while the result register is empty or
//                    being drained; when the receiver holds off out_ready the
//                    result is held and input is stalled after one item.
//   Reset          : arst_n clears the parser to hunting for the ID byte,
//                    counters and sum to zero, frame_id to 0, max_length to
//                    65535, and empties the result register.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver
	import lpfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// event output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  payload_byte,
	output logic [15:0] payload_index,
	output logic [7:0]  computed_sum,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers
	logic [7:0]  frame_id_q;
	logic [15:0] max_length_q;

	// Parser state
	phase_t      phase_q, phase_d;
	logic [7:0]  length_high_q, length_high_d;
	logic [15:0] frame_length_q, frame_length_d;
	logic [15:0] byte_count_q, byte_count_d;
	logic [7:0]  running_sum_q, running_sum_d;

	// Result register
	logic        out_valid_q;
	event_t      event_q, event_d;
	logic [7:0]  pbyte_q, pbyte_d;
	logic [15:0] pidx_q, pidx_d;
	logic [7:0]  sum_q;

	logic        in_acc;
	logic        cfg_wr;
	logic [15:0] len_word;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// APB write: index taken from the word address bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_id_q   <= FRAME_ID_RESET;
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FRAME_ID:   frame_id_q   <= pwdata[7:0];
				REG_MAX_LENGTH: max_length_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// APB read
	always_comb begin
		case (paddr[2])
			REG_FRAME_ID:   prdata = {24'd0, frame_id_q};
			REG_MAX_LENGTH: prdata = {16'd0, max_length_q};
			default:        prdata = 32'd0;
		endcase
	end

	// Accept a byte whenever the result register is free or draining
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	assign len_word = {length_high_q, rx_byte};

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_ID: begin
				if (rx_byte == frame_id_q) phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: phase_d = PH_LEN_LO;
			PH_LEN_LO: begin
				if (len_word > max_length_q) phase_d = PH_ID;
				else phase_d = PH_DATA;
			end
			PH_DATA: begin
				if (byte_count_q >= frame_length_q) phase_d = PH_ID;
			end
			default: phase_d = PH_ID;
		endcase
	end

	// Datapath and result for the current byte
	always_comb begin
		length_high_d  = length_high_q;
		frame_length_d = frame_length_q;
		byte_count_d   = byte_count_q;
		running_sum_d  = running_sum_q;
		event_d        = EV_HEADER;
		pbyte_d        = 8'd0;
		pidx_d         = 16'd0;
		case (phase_q)
			PH_ID: begin
				if (rx_byte == frame_id_q) begin
					byte_count_d  = 16'd0;
					running_sum_d = 8'd0;
				end else begin
					event_d = EV_BAD_ID;
				end
			end
			PH_LEN_HI: length_high_d = rx_byte;
			PH_LEN_LO: begin
				frame_length_d = len_word;
				if (len_word > max_length_q) begin
					event_d = EV_OVERSIZE;
				end else begin
					byte_count_d  = 16'd0;
					running_sum_d = 8'd0;
				end
			end
			PH_DATA: begin
				if (byte_count_q < frame_length_q) begin
					event_d       = EV_PAYLOAD;
					pbyte_d       = rx_byte;
					pidx_d        = byte_count_q;
					running_sum_d = running_sum_q + rx_byte;
					byte_count_d  = byte_count_q + 16'd1;
				end else if (rx_byte == running_sum_q) begin
					event_d = EV_GOOD;
				end else begin
					event_d = EV_BAD_SUM;
				end
			end
			default: ;
		endcase
	end

	// Parser state: advance on every accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_ID;
			length_high_q  <= 8'd0;
			frame_length_q <= 16'd0;
			byte_count_q   <= 16'd0;
			running_sum_q  <= 8'd0;
		end else if (in_acc) begin
			phase_q        <= phase_d;
			length_high_q  <= length_high_d;
			frame_length_q <= frame_length_d;
			byte_count_q   <= byte_count_d;
			running_sum_q  <= running_sum_d;
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload, hold while stalled
	always_ff @(posedge clk) begin
		if (in_acc) begin
			event_q <= event_d;
			pbyte_q <= pbyte_d;
			pidx_q  <= pidx_d;
			sum_q   <= running_sum_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = event_q;
	assign payload_byte  = pbyte_q;
	assign payload_index = pidx_q;
	assign computed_sum  = sum_q;

	// Payload fields are zero on every event other than a payload byte
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res != EV_PAYLOAD) |-> (payload_byte == 8'd0 && payload_index == 16'd0))
		else $error("payload fields nonzero on non-payload event");

	// The byte counter never runs past the frame length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (byte_count_q <= frame_length_q))
		else $error("byte count beyond frame length");

	// A mismatching byte while hunting keeps hunting and reports bad id
	a_bad_id: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && phase_q == PH_ID && rx_byte != frame_id_q)
		|=> (phase_q == PH_ID && out_valid && event_res == EV_BAD_ID))
		else $error("bad id not handled");

endmodule
